// ===== rtl/mbrot_pkg.sv =====
// Shared types, constants and helper functions for the Mandelbrot pixel block.
// Used by mbrot_div and mandelbrot_escape_time_pixel; no dependencies.
`timescale 1ns / 1ps

package mbrot_pkg;

  // Fixed-point format: signed Q6.26
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = COORD_BITS - 6;

  // Field widths
  localparam int IDX_BITS   = 12;
  localparam int CNT_BITS   = 13;
  localparam int ITER_BITS  = 10;
  localparam int CHAN_BITS  = 8;
  localparam int CIDX_BITS  = 3;

  // Coordinate mapping: span is one bit wider than a coordinate,
  // span * index fits SPROD_BITS signed, its magnitude fits DVD_BITS.
  localparam int SPAN_BITS  = COORD_BITS + 1;
  localparam int SPROD_BITS = SPAN_BITS + IDX_BITS + 1;
  localparam int DVD_BITS   = SPROD_BITS - 1;
  localparam int DCNT_BITS  = $clog2(DVD_BITS + 1);
  localparam int MAPSUM_BITS = DVD_BITS + 2;

  // Shared multiplier: A side holds the span, B side the index or a
  // box-limited z component (|z| <= 2.0 needs FRAC_BITS + 3 bits).
  localparam int MUL_A_BITS = SPAN_BITS;
  localparam int ZB_BITS    = FRAC_BITS + 3;
  localparam int MUL_B_BITS = ZB_BITS;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int ACC_BITS   = FRAC_BITS + 4;

  localparam int PALETTE_ENTRIES = 16;

  typedef logic        [IDX_BITS-1:0]   idx_t;
  typedef logic        [CNT_BITS-1:0]   count_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [ITER_BITS-1:0]  iter_t;
  typedef logic        [CHAN_BITS-1:0]  chan_t;
  typedef logic        [CIDX_BITS-1:0]  cfg_idx_t;
  typedef logic        [COORD_BITS-1:0] cfg_data_t;
  typedef logic        [DVD_BITS-1:0]   dvd_t;

  // Box limit 2.0
  localparam coord_t BOX_LIM = coord_t'(2) <<< FRAC_BITS;

  // Configuration register indexes
  localparam cfg_idx_t REG_OUTER_COUNT = 3'd0;
  localparam cfg_idx_t REG_INNER_COUNT = 3'd1;
  localparam cfg_idx_t REG_REAL_MIN    = 3'd2;
  localparam cfg_idx_t REG_REAL_MAX    = 3'd3;
  localparam cfg_idx_t REG_IMAG_MIN    = 3'd4;
  localparam cfg_idx_t REG_IMAG_MAX    = 3'd5;
  localparam cfg_idx_t REG_ITER_LIMIT  = 3'd6;

  // Reset values
  localparam count_t RST_OUTER_COUNT = 13'd640;
  localparam count_t RST_INNER_COUNT = 13'd480;
  localparam coord_t RST_REAL_MIN    = -32'sd134217728;
  localparam coord_t RST_REAL_MAX    = 32'sd67108864;
  localparam coord_t RST_IMAG_MIN    = -32'sd67108864;
  localparam coord_t RST_IMAG_MAX    = 32'sd67108864;
  localparam iter_t  RST_ITER_LIMIT  = 10'd50;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPAN,
    ST_MUL,
    ST_DSTART,
    ST_DWAIT,
    ST_CHECK,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // Clamp a mapped coordinate sum to the coordinate range
  function automatic coord_t sat_map(input logic signed [MAPSUM_BITS-1:0] v);
    logic signed [MAPSUM_BITS-1:0] hi;
    logic signed [MAPSUM_BITS-1:0] lo;
    hi = MAPSUM_BITS'(coord_t'({1'b0, {(COORD_BITS-1){1'b1}}}));
    lo = -hi - MAPSUM_BITS'(1);
    if (v > hi) return coord_t'(hi);
    else if (v < lo) return coord_t'(lo);
    else return coord_t'(v);
  endfunction

  // Clamp an iteration sum (one bit of growth) to the coordinate range
  function automatic coord_t sat_step(input logic signed [COORD_BITS:0] v);
    if (v[COORD_BITS] != v[COORD_BITS-1])
      return {v[COORD_BITS], {(COORD_BITS-1){~v[COORD_BITS]}}};
    else
      return coord_t'(v[COORD_BITS-1:0]);
  endfunction

  // 16-entry color palette, {red, green, blue}
  function automatic logic [3*CHAN_BITS-1:0] palette(input logic [3:0] k);
    case (k)
      4'd0:    return {8'd66,  8'd30,  8'd15};
      4'd1:    return {8'd25,  8'd7,   8'd26};
      4'd2:    return {8'd9,   8'd1,   8'd47};
      4'd3:    return {8'd4,   8'd4,   8'd73};
      4'd4:    return {8'd0,   8'd7,   8'd100};
      4'd5:    return {8'd12,  8'd44,  8'd138};
      4'd6:    return {8'd24,  8'd82,  8'd177};
      4'd7:    return {8'd57,  8'd125, 8'd209};
      4'd8:    return {8'd134, 8'd181, 8'd229};
      4'd9:    return {8'd211, 8'd236, 8'd248};
      4'd10:   return {8'd241, 8'd233, 8'd191};
      4'd11:   return {8'd248, 8'd201, 8'd95};
      4'd12:   return {8'd255, 8'd170, 8'd0};
      4'd13:   return {8'd204, 8'd128, 8'd0};
      4'd14:   return {8'd153, 8'd87,  8'd0};
      4'd15:   return {8'd106, 8'd52,  8'd3};
      default: return {8'd66,  8'd30,  8'd15};
    endcase
  endfunction

endpackage

// ===== rtl/mbrot_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle (unsigned).
// Depends on mbrot_pkg for widths.
`timescale 1ns / 1ps

module mbrot_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  mbrot_pkg::dvd_t   dividend,
  input  mbrot_pkg::count_t divisor,
  output logic              done,
  output mbrot_pkg::dvd_t   quotient
);
  import mbrot_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DCNT_BITS-1:0] cnt_r;
  dvd_t                 dvd_r;
  count_t               rem_r;
  count_t               dvs_r;

  logic [CNT_BITS:0]    trial;
  logic                 fits;

  // Trial subtract of the shifted remainder
  assign trial = {rem_r, dvd_r[DVD_BITS-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_BITS'(DVD_BITS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - DCNT_BITS'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_BITS-2:0], fits};
      if (fits) rem_r <= CNT_BITS'(trial - {1'b0, dvs_r});
      else      rem_r <= trial[CNT_BITS-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

  // Checks
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r |=> busy_r)
    else $error("divider did not start");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");

endmodule

// ===== rtl/mandelbrot_escape_time_pixel.sv =====
// Mandelbrot escape-time pixel: top level with config registers and sequencer.
// Depends on mbrot_pkg and mbrot_div.
//
//  channel | ports                                             | dir
//  --------+---------------------------------------------------+-----
//  in      | in_valid, in_ready, in_outer_index, in_inner_index | in
//  out     | out_valid, out_ready, out_iteration_count,        | out
//          | out_red, out_green, out_blue                      |
//  cfg     | cfg_we, cfg_index, cfg_wdata                      | in
//
// Per item: two coordinate mappings, each through the one-bit-per-cycle
// divider, then one z^2 + c step per escape-count increment on the single
// shared multiplier (three products, then the update of z and the count).
// One item at a time; in_ready is high while the sequencer is idle, even if
// the previous result is still waiting in the output register.
// A stalled output holds the sequencer in its finish state. Reset is
// synchronous; the config registers return to their documented defaults.
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mbrot_pkg::idx_t       in_outer_index,
  input  mbrot_pkg::idx_t       in_inner_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mbrot_pkg::iter_t      out_iteration_count,
  output mbrot_pkg::chan_t      out_red,
  output mbrot_pkg::chan_t      out_green,
  output mbrot_pkg::chan_t      out_blue,
  input  logic                  cfg_we,
  input  mbrot_pkg::cfg_idx_t   cfg_index,
  input  mbrot_pkg::cfg_data_t  cfg_wdata
);
  import mbrot_pkg::*;

  // Configuration registers
  count_t outer_count_r, inner_count_r;
  coord_t real_min_r, real_max_r, imag_min_r, imag_max_r;
  iter_t  iter_limit_r;

  // Sequencer and datapath
  state_t state_r, state_nxt;
  logic   sel_re_r;             // 0: mapping the imaginary part, 1: the real part
  idx_t   outer_r, inner_r;
  logic signed [SPAN_BITS-1:0]  span_r;
  logic signed [PROD_BITS-1:0]  prod_r;
  logic signed [ACC_BITS-1:0]   acc_r;
  logic   neg_r;
  coord_t cr_r, ci_r, zr_r, zi_r;
  iter_t  n_r;

  // Output register
  logic   out_valid_r;
  iter_t  out_count_r;
  chan_t  out_red_r, out_green_r, out_blue_r;

  // Combinational
  logic signed [MUL_A_BITS-1:0]  mul_a;
  logic signed [MUL_B_BITS-1:0]  mul_b;
  logic signed [PROD_BITS-1:0]   mul_p;
  logic signed [SPROD_BITS-1:0]  sprod;
  logic signed [SPROD_BITS-1:0]  sprod_neg;
  dvd_t   dvd_mag;
  count_t map_count;
  coord_t map_lo, map_hi;
  idx_t   map_idx;
  logic   div_start, div_done;
  dvd_t   div_quot;
  logic signed [MAPSUM_BITS-1:0] q_signed;
  coord_t map_coord;
  logic   in_box, step_ok, out_load;
  logic signed [ZB_BITS-1:0]     zr_b, zi_b;
  logic signed [COORD_BITS:0]    nr_sum, ni_sum;
  logic [3*CHAN_BITS-1:0]        color;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_count_r <= RST_OUTER_COUNT;
      inner_count_r <= RST_INNER_COUNT;
      real_min_r    <= RST_REAL_MIN;
      real_max_r    <= RST_REAL_MAX;
      imag_min_r    <= RST_IMAG_MIN;
      imag_max_r    <= RST_IMAG_MAX;
      iter_limit_r  <= RST_ITER_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OUTER_COUNT: outer_count_r <= cfg_wdata[CNT_BITS-1:0];
        REG_INNER_COUNT: inner_count_r <= cfg_wdata[CNT_BITS-1:0];
        REG_REAL_MIN:    real_min_r    <= coord_t'(cfg_wdata);
        REG_REAL_MAX:    real_max_r    <= coord_t'(cfg_wdata);
        REG_IMAG_MIN:    imag_min_r    <= coord_t'(cfg_wdata);
        REG_IMAG_MAX:    imag_max_r    <= coord_t'(cfg_wdata);
        REG_ITER_LIMIT:  iter_limit_r  <= cfg_wdata[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Mapping operands for the axis in progress
  assign map_lo    = sel_re_r ? real_min_r    : imag_min_r;
  assign map_hi    = sel_re_r ? real_max_r    : imag_max_r;
  assign map_count = sel_re_r ? inner_count_r : outer_count_r;
  assign map_idx   = sel_re_r ? inner_r       : outer_r;

  // z components limited to the box for the multiplier
  assign zr_b = zr_r[ZB_BITS-1:0];
  assign zi_b = zi_r[ZB_BITS-1:0];

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL: begin
        mul_a = span_r;
        mul_b = MUL_B_BITS'({1'b0, map_idx});
      end
      ST_MUL_RR: begin
        mul_a = MUL_A_BITS'(zr_b);
        mul_b = zr_b;
      end
      ST_MUL_II: begin
        mul_a = MUL_A_BITS'(zi_b);
        mul_b = zi_b;
      end
      ST_MUL_RI: begin
        mul_a = MUL_A_BITS'(zr_b);
        mul_b = zi_b;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Divider feed: magnitude of span * index
  assign sprod     = prod_r[SPROD_BITS-1:0];
  assign sprod_neg = -sprod;
  assign dvd_mag   = sprod[SPROD_BITS-1] ? sprod_neg[DVD_BITS-1:0] : sprod[DVD_BITS-1:0];
  assign div_start = (state_r == ST_DSTART);

  mbrot_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_mag),
    .divisor  (map_count),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Coordinate = min + quotient (truncated toward zero), saturated
  always_comb begin
    if (map_count == '0)
      q_signed = '0;
    else if (neg_r)
      q_signed = -$signed({2'b00, div_quot});
    else
      q_signed = $signed({2'b00, div_quot});
  end
  assign map_coord = sat_map(MAPSUM_BITS'(map_lo) + q_signed);

  // Escape test and step sums
  assign in_box  = (zr_r <= BOX_LIM) && (zr_r >= -BOX_LIM) &&
                   (zi_r <= BOX_LIM) && (zi_r >= -BOX_LIM);
  assign step_ok = in_box && (n_r < iter_limit_r);
  assign nr_sum  = (COORD_BITS+1)'(acc_r) + (COORD_BITS+1)'(cr_r);
  assign ni_sum  = (COORD_BITS+1)'($signed(prod_r[FRAC_BITS-1 +: COORD_BITS])) +
                   (COORD_BITS+1)'(ci_r);

  assign out_load = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_SPAN;
      ST_SPAN:   state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT:  if (div_done) state_nxt = sel_re_r ? ST_CHECK : ST_SPAN;
      ST_CHECK:  state_nxt = step_ok ? ST_MUL_RR : ST_FINISH;
      ST_MUL_RR: state_nxt = ST_MUL_II;
      ST_MUL_II: state_nxt = ST_MUL_RI;
      ST_MUL_RI: state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_CHECK;
      ST_FINISH: if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        outer_r  <= in_outer_index;
        inner_r  <= in_inner_index;
        sel_re_r <= 1'b0;
        n_r      <= '0;
      end
      ST_SPAN:   span_r <= SPAN_BITS'(map_hi) - SPAN_BITS'(map_lo);
      ST_MUL:    prod_r <= mul_p;
      ST_DSTART: neg_r  <= sprod[SPROD_BITS-1];
      ST_DWAIT: begin
        if (div_done) begin
          sel_re_r <= 1'b1;
          if (sel_re_r) begin
            cr_r <= map_coord;
            zr_r <= map_coord;
          end else begin
            ci_r <= map_coord;
            zi_r <= map_coord;
          end
        end
      end
      ST_MUL_RR: prod_r <= mul_p;
      ST_MUL_II: begin
        prod_r <= mul_p;
        acc_r  <= prod_r[FRAC_BITS +: ACC_BITS];
      end
      ST_MUL_RI: begin
        prod_r <= mul_p;
        acc_r  <= acc_r - prod_r[FRAC_BITS +: ACC_BITS];
      end
      ST_UPDATE: begin
        zr_r <= sat_step(nr_sum);
        zi_r <= sat_step(ni_sum);
        n_r  <= n_r + ITER_BITS'(1);
      end
      default: ;
    endcase
  end

  // Output register
  assign color = palette(n_r[3:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= n_r;
      out_red_r   <= color[3*CHAN_BITS-1:2*CHAN_BITS];
      out_green_r <= color[2*CHAN_BITS-1:CHAN_BITS];
      out_blue_r  <= color[CHAN_BITS-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_red             = out_red_r;
  assign out_green           = out_green_r;
  assign out_blue            = out_blue_r;

  // Checks
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_SPAN)
    else $error("accepted item did not start the mapping");
  a_box_on_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL_RR |-> in_box)
    else $error("squaring a z outside the box");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DWAIT)
    else $error("divider result arrived outside the wait state");
  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FINISH))
    else $error("result raised outside the finish state");

endmodule
